[hdl/itp_pkg.sv]
package itp_pkg;

  localparam int DEF_STACK_DEPTH = 32;
  localparam int QUEUE_DEPTH     = 2;
  localparam int CODE_W          = 3;
  localparam int PREC_W          = 3;

  typedef logic [CODE_W-1:0] code_t;
  typedef logic [PREC_W-1:0] prec_t;

  localparam code_t CODE_LPAR = 3'd0;
  localparam code_t CODE_ADD  = 3'd1;
  localparam code_t CODE_SUB  = 3'd2;
  localparam code_t CODE_MUL  = 3'd3;
  localparam code_t CODE_DIV  = 3'd4;
  localparam code_t CODE_POW  = 3'd5;
  localparam code_t CODE_NONE = 3'd7;

  localparam prec_t PREC_LPAR = 3'd6;
  localparam prec_t PREC_POW  = 3'd5;
  localparam prec_t PREC_MUL  = 3'd4;
  localparam prec_t PREC_ADD  = 3'd2;
  localparam prec_t PREC_NONE = 3'd0;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LPAR  = 8'h28;
  localparam logic [7:0] CHAR_RPAR  = 8'h29;
  localparam logic [7:0] CHAR_MUL   = 8'h2a;
  localparam logic [7:0] CHAR_ADD   = 8'h2b;
  localparam logic [7:0] CHAR_SUB   = 8'h2d;
  localparam logic [7:0] CHAR_DIV   = 8'h2f;
  localparam logic [7:0] CHAR_POW   = 8'h5e;

  typedef enum logic [1:0] {
    CLS_SKIP,
    CLS_OPERAND,
    CLS_CLOSE,
    CLS_OPER
  } cls_t;

  typedef struct packed {
    cls_t       cls;
    logic [7:0] ch;
    code_t      code;
    logic       last;
  } cmd_t;

  function automatic code_t char_code(logic [7:0] c);
    code_t r;
    case (c)
      CHAR_LPAR: r = CODE_LPAR;
      CHAR_ADD:  r = CODE_ADD;
      CHAR_SUB:  r = CODE_SUB;
      CHAR_MUL:  r = CODE_MUL;
      CHAR_DIV:  r = CODE_DIV;
      CHAR_POW:  r = CODE_POW;
      default:   r = CODE_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] code_char(code_t code);
    logic [7:0] r;
    case (code)
      CODE_LPAR: r = CHAR_LPAR;
      CODE_ADD:  r = CHAR_ADD;
      CODE_SUB:  r = CHAR_SUB;
      CODE_MUL:  r = CHAR_MUL;
      CODE_DIV:  r = CHAR_DIV;
      CODE_POW:  r = CHAR_POW;
      default:   r = CHAR_NUL;
    endcase
    return r;
  endfunction

  function automatic prec_t code_prec(code_t code);
    prec_t r;
    case (code)
      CODE_LPAR: r = PREC_LPAR;
      CODE_ADD:  r = PREC_ADD;
      CODE_SUB:  r = PREC_ADD;
      CODE_MUL:  r = PREC_MUL;
      CODE_DIV:  r = PREC_MUL;
      CODE_POW:  r = PREC_POW;
      default:   r = PREC_NONE;
    endcase
    return r;
  endfunction

endpackage

[hdl/itp_ram.sv]
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/itp_front.sv]
module itp_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_char,
  input  logic              is_last,
  input  logic              q_full,
  output logic              q_push,
  output itp_pkg::cmd_t     q_data
);

  itp_pkg::code_t code;

  assign code     = itp_pkg::char_code(in_char);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_data.ch   = in_char;
    q_data.code = code;
    q_data.last = is_last;
    priority if (in_char == itp_pkg::CHAR_SPACE) begin
      q_data.cls = itp_pkg::CLS_SKIP;
    end else if (in_char == itp_pkg::CHAR_RPAR) begin
      q_data.cls = itp_pkg::CLS_CLOSE;
    end else if (code != itp_pkg::CODE_NONE) begin
      q_data.cls = itp_pkg::CLS_OPER;
    end else begin
      q_data.cls = itp_pkg::CLS_OPERAND;
    end
  end

endmodule

[hdl/itp_fifo.sv]
module itp_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  itp_pkg::cmd_t push_data,
  output logic          full,
  output logic          valid,
  output itp_pkg::cmd_t data,
  input  logic          pop
);

  localparam int PW = $clog2(itp_pkg::QUEUE_DEPTH);
  localparam int FW = $clog2(itp_pkg::QUEUE_DEPTH + 1);

  itp_pkg::cmd_t   entries [itp_pkg::QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [FW-1:0]   fill;
  logic            do_push;
  logic            do_pop;

  assign full    = fill == FW'(itp_pkg::QUEUE_DEPTH);
  assign valid   = fill != '0;
  assign data    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(itp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(itp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + FW'(1);
        2'b01:   fill <= fill - FW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

[hdl/itp_back.sv]
module itp_back #(
  parameter int STACK_DEPTH = itp_pkg::DEF_STACK_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  itp_pkg::cmd_t q_data,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_char,
  output logic          has_char,
  output logic          run_last,
  output logic          expr_end,
  output logic          overflow
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAIN,
    S_FLUSH,
    S_DONE
  } state_t;

  state_t          state;
  itp_pkg::cmd_t   cmd;
  logic [CW-1:0]   count;
  itp_pkg::code_t  top_reg;
  logic            fresh;
  logic            overflow_seen;
  logic            held_valid;
  logic [7:0]      held_char;

  itp_pkg::code_t  rd_data;
  itp_pkg::code_t  top;
  logic            nonempty;
  logic            out_free;
  logic            can_emit;
  logic            stop_oper;
  logic            emit_req;
  logic            emit_fire;
  logic [7:0]      emit_char;
  logic            pop_req;
  logic            push_req;
  logic            adv;
  logic            ram_we;
  logic            out_load;

  itp_ram #(
    .WIDTH (itp_pkg::CODE_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (AW'(count)),
    .wr_data (cmd.code),
    .rd_addr (AW'(count - CW'(2))),
    .rd_data (rd_data)
  );

  assign top       = fresh ? rd_data : top_reg;
  assign nonempty  = count != '0;
  assign out_free  = !out_valid || !out_stall;
  assign can_emit  = !held_valid || out_free;
  assign stop_oper = !nonempty || top == itp_pkg::CODE_LPAR ||
                     itp_pkg::code_prec(top) < itp_pkg::code_prec(cmd.code);
  assign emit_fire = emit_req && can_emit;
  assign ram_we    = push_req && count != FULL;
  assign q_pop     = state == S_IDLE;
  assign out_load  = (emit_fire && held_valid) ||
                     (state == S_DONE && (held_valid || cmd.last) && out_free);

  always_comb begin
    emit_req  = 1'b0;
    emit_char = itp_pkg::code_char(top);
    pop_req   = 1'b0;
    push_req  = 1'b0;
    adv       = 1'b0;
    unique case (state)
      S_MAIN: begin
        unique case (cmd.cls)
          itp_pkg::CLS_SKIP: begin
            adv = 1'b1;
          end
          itp_pkg::CLS_OPERAND: begin
            emit_req  = 1'b1;
            emit_char = cmd.ch;
            adv       = can_emit;
          end
          itp_pkg::CLS_CLOSE: begin
            priority if (nonempty && top != itp_pkg::CODE_LPAR) begin
              emit_req = 1'b1;
              pop_req  = can_emit;
            end else if (nonempty) begin
              pop_req = 1'b1;
              adv     = 1'b1;
            end else begin
              adv = 1'b1;
            end
          end
          itp_pkg::CLS_OPER: begin
            if (!stop_oper) begin
              emit_req = 1'b1;
              pop_req  = can_emit;
            end else begin
              push_req = 1'b1;
              adv      = 1'b1;
            end
          end
        endcase
      end
      S_FLUSH: begin
        if (nonempty) begin
          emit_req = 1'b1;
          pop_req  = can_emit;
        end
      end
      S_IDLE, S_DONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      fresh         <= 1'b0;
      overflow_seen <= 1'b0;
      held_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (push_req && count != FULL) begin
        top_reg <= cmd.code;
      end else if (fresh) begin
        top_reg <= rd_data;
      end
      fresh <= pop_req;

      if (emit_fire) begin
        if (held_valid) begin
          out_char  <= held_char;
          has_char  <= 1'b1;
          run_last  <= 1'b0;
          expr_end  <= 1'b0;
          overflow  <= overflow_seen;
        end
        held_char  <= emit_char;
        held_valid <= 1'b1;
      end

      if (pop_req) begin
        count <= count - CW'(1);
      end

      if (push_req) begin
        if (count != FULL) begin
          count <= count + CW'(1);
        end else begin
          overflow_seen <= 1'b1;
        end
      end

      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cmd   <= q_data;
            state <= S_MAIN;
          end
        end
        S_MAIN: begin
          if (adv) begin
            state <= cmd.last ? S_FLUSH : S_DONE;
          end
        end
        S_FLUSH: begin
          if (!nonempty) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (held_valid || cmd.last) begin
            if (out_free) begin
              out_char   <= held_valid ? held_char : itp_pkg::CHAR_NUL;
              has_char   <= held_valid;
              run_last   <= 1'b1;
              expr_end   <= cmd.last;
              overflow   <= overflow_seen;
              held_valid <= 1'b0;
              if (cmd.last) begin
                overflow_seen <= 1'b0;
              end
              state <= S_IDLE;
            end
          end else begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

[hdl/infix_to_postfix_converter_top.sv]
// Shunting-yard infix to postfix converter. Characters arrive one per transaction with a
// flag on the last one of the expression; postfix characters leave one per transaction,
// with run_last closing the results of each input and expr_end closing the expression.
// A classifier and a two-entry queue take input characters independently of the output
// side. The operator stack lives in a single-port-write RAM with registered read, the top
// entry cached in a register, so one operator is popped per cycle while the output is not
// stalled. The back end takes each character from the queue in its idle state, handles it
// in the main state, flushes the remaining operators in the flush state on the last character
// of an expression, and hands the result over in the done state, waiting while the output is
// stalled; the stack RAM holds STACK_DEPTH entries and needs no clearing after reset.
module infix_to_postfix_converter_top #(
  parameter int STACK_DEPTH = itp_pkg::DEF_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char,
  output logic       has_char,
  output logic       run_last,
  output logic       expr_end,
  output logic       overflow
);

  logic          q_full;
  logic          q_push;
  itp_pkg::cmd_t q_in;
  logic          q_valid;
  itp_pkg::cmd_t q_out;
  logic          q_pop;

  itp_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_char  (in_char),
    .is_last  (is_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_in)
  );

  itp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .valid     (q_valid),
    .data      (q_out),
    .pop       (q_pop)
  );

  itp_back #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_out),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .has_char  (has_char),
    .run_last  (run_last),
    .expr_end  (expr_end),
    .overflow  (overflow)
  );

endmodule

[hdl/itp_checker.sv]
module itp_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic [7:0] in_char,
  input logic       is_last,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_char,
  input logic       has_char,
  input logic       run_last,
  input logic       expr_end,
  input logic       overflow
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable({in_char, is_last}))
    else $error("stalled input changed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid &&
      $stable({out_char, has_char, run_last, expr_end, overflow}))
    else $error("stalled result changed");

  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && expr_end |-> run_last)
    else $error("expression end without run end");

  a_empty_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !has_char |-> out_char == 8'd0 && run_last && expr_end)
    else $error("empty result outside expression end");

  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("not idle after reset");

endmodule

bind infix_to_postfix_converter_top itp_checker u_itp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_char   (in_char),
  .is_last   (is_last),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_char  (out_char),
  .has_char  (has_char),
  .run_last  (run_last),
  .expr_end  (expr_end),
  .overflow  (overflow)
);
